[design/cv3f_pkg.sv]
// Shared constants, types and arithmetic helpers for the 3x3 image filter.
package cv3f_pkg;

  // Line store depth: the widest row the block handles
  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);

  // Configuration field widths
  localparam int WID_W      = 11;
  localparam int HGT_W      = 12;
  localparam int ROW_W      = HGT_W + 1;   // input row runs one past the frame while draining

  // Pixel layout: red in the low byte, then green, then blue
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = CH_W * NUM_CH;
  localparam int LINE_W     = 2 * PIX_W;   // {upper row, middle row} per column

  // Kernel sums fit -4096..4095
  localparam int SUM_W      = 13;
  localparam int EMBOSS_BIAS = 128;
  localparam int CH_MAX     = 255;

  // Divide by nine: multiply by ceil(2^16 / 9) and keep the top bits
  localparam int DIV9_MUL   = 7282;
  localparam int DIV9_SH    = 16;
  localparam int DIV9_PW    = (SUM_W - 1) + 13;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = CNT_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

  typedef enum logic [1:0] {
    MODE_BLUR    = 2'd0,
    MODE_SHARPEN = 2'd1,
    MODE_EMBOSS  = 2'd2,
    MODE_EDGE    = 2'd3
  } mode_t;

  // Window taps of one channel, row-major, index row*3+col
  typedef logic [8:0][CH_W-1:0] taps_t;

  // Per-item control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic interior;
    logic last;
  } ctl_t;

  // One queued result beat
  typedef struct packed {
    logic            last;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } res_t;

  // Truncating divide by nine for sums up to 9*255
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-2:0] s);
    logic [DIV9_PW-1:0] prod;
    prod = DIV9_PW'(s) * DIV9_PW'(DIV9_MUL);
    return prod[DIV9_SH +: CH_W];
  endfunction

  // Saturate a signed sum to one channel
  function automatic logic [CH_W-1:0] clamp8(input logic signed [SUM_W-1:0] s);
    logic [CH_W-1:0] r;
    if (s < $signed(SUM_W'(0))) begin
      r = '0;
    end else if (s > $signed(SUM_W'(CH_MAX))) begin
      r = CH_W'(CH_MAX);
    end else begin
      r = s[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

[design/cv3f_ram.sv]
// Generic single-clock RAM: one write port, one registered read port.
module cv3f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/cv3f_chan_sum.sv]
// Kernel sum of one color channel over the 3x3 window for the selected filter.
module cv3f_chan_sum (
  input  cv3f_pkg::taps_t                      taps,
  input  cv3f_pkg::mode_t                      mode,
  output logic signed [cv3f_pkg::SUM_W-1:0]    sum
);
  import cv3f_pkg::*;

  logic signed [SUM_W-1:0] t [9];
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] center5;
  logic signed [SUM_W-1:0] center9;

  // Zero-extend the taps into signed sum width
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      t[i] = $signed(SUM_W'(taps[i]));
    end
  end

  assign total   = t[0] + t[1] + t[2] + t[3] + t[4] + t[5] + t[6] + t[7] + t[8];
  assign center5 = (t[4] <<< 2) + t[4];
  assign center9 = (t[4] <<< 3) + t[4];

  always_comb begin
    case (mode)
      MODE_BLUR:    sum = total;
      MODE_SHARPEN: sum = center5 - t[1] - t[3] - t[5] - t[7];
      MODE_EMBOSS:  sum = $signed(SUM_W'(EMBOSS_BIAS)) - (t[0] <<< 1) - t[1] - t[3]
                          + t[4] + t[5] + t[7] + (t[8] <<< 1);
      MODE_EDGE:    sum = center9 - total;   // 8*center minus the eight neighbors
      default:      sum = total;
    endcase
  end

endmodule

[design/conv3x3_image_filter_core.sv]
// Top level of the streaming 3x3 RGB image filter.
//
// Takes one RGB pixel per clock in raster order and returns one filtered
// pixel per clock once the pipeline is primed, when not stalled; each
// result is the filtered version of the pixel image_width+1 input beats
// earlier, so width+1 pad beats after the frame drain the last results,
// and the final one carries out_last_pixel. Border pixels, and every pixel
// of an image narrower or shorter than three, pass through unchanged. The
// previous two rows live in one 1024 x 48 line RAM that is read and written
// once per beat, which sets the rate of one pixel per clock. Accepted beats
// pass the line read, window update, kernel sum, then divide or clamp into
// an eight-entry result queue, which lets input keep flowing while the
// output side stalls, and in_stall rises only when that queue could fill.
// Configuration writes are always taken (cfg_ready is high) and must be
// made between frames; the line RAM needs no clearing after reset.
module conv3x3_image_filter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // pixel input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cv3f_pkg::CH_W-1:0]             in_pixel_red,
  input  logic [cv3f_pkg::CH_W-1:0]             in_pixel_green,
  input  logic [cv3f_pkg::CH_W-1:0]             in_pixel_blue,
  input  logic                                  in_is_pad,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cv3f_pkg::CH_W-1:0]             out_red,
  output logic [cv3f_pkg::CH_W-1:0]             out_green,
  output logic [cv3f_pkg::CH_W-1:0]             out_blue,
  output logic                                  out_last_pixel,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cv3f_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cv3f_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import cv3f_pkg::*;

  // ---------------- configuration ----------------
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  mode_t            mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
      mode_r   <= MODE_BLUR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        CFG_MODE:   mode_r   <= mode_t'(cfg_data[1:0]);
        default:    ;
      endcase
    end
  end

  // Effective size: zero counts as one, width saturates at the line store depth
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HGT_W'(1) : height_r;
  end

  // ---------------- raster position counters ----------------
  logic [COL_W-1:0] in_col_r,  in_col_nxt;
  logic [ROW_W-1:0] in_row_r,  in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [HGT_W-1:0] out_row_r, out_row_nxt;

  logic             acc;        // input beat accepted
  logic             take;       // accepted beat that enters the pipeline
  logic             ignore;     // pad before any pixel of a frame
  logic             pad_eff;
  ctl_t             ctl_a;
  logic [PIX_W-1:0] px_a;
  logic [WID_W-1:0] in_col_inc;
  logic [WID_W-1:0] out_col_inc;

  assign acc     = in_valid && !in_stall;
  assign ignore  = in_is_pad && (in_col_r == '0) && (in_row_r == '0);
  assign take    = acc && !ignore;
  assign pad_eff = in_is_pad || (in_row_r >= ROW_W'(h_eff));
  assign px_a    = pad_eff ? '0 : {in_pixel_blue, in_pixel_green, in_pixel_red};

  // Result decisions for this beat, all from current counters
  always_comb begin
    ctl_a.emit     = (in_row_r >= ROW_W'(2)) ||
                     ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    ctl_a.interior = (out_col_r != '0) &&
                     ((WID_W'(out_col_r) + WID_W'(1)) < w_eff) &&
                     (out_row_r != '0) &&
                     ((ROW_W'(out_row_r) + ROW_W'(1)) < ROW_W'(h_eff));
    ctl_a.last     = (out_row_r >= (h_eff - HGT_W'(1))) &&
                     (WID_W'(out_col_r) >= (w_eff - WID_W'(1)));
  end

  assign in_col_inc  = WID_W'(in_col_r) + WID_W'(1);
  assign out_col_inc = WID_W'(out_col_r) + WID_W'(1);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (in_col_inc >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_inc[COL_W-1:0];
      end
      if (ctl_a.emit) begin
        if (ctl_a.last) begin
          // end of frame: everything restarts at the origin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_inc >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HGT_W'(1);
        end else begin
          out_col_nxt = out_col_inc[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------- stage 1: line RAM read, window shift ----------------
  logic              v1_r;
  ctl_t              ctl1_r;
  logic [PIX_W-1:0]  px1_r;
  logic [COL_W-1:0]  col1_r;
  logic              fwd1_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic [LINE_W-1:0] ram_q;
  logic [LINE_W-1:0] line1;
  logic [PIX_W-1:0]  top1, mid1;
  logic [LINE_W-1:0] line_wr;

  // Same column read and written in one cycle: one-pixel rows, or column zero as a frame restarts
  logic fwd_nxt;
  assign fwd_nxt = v1_r && (col1_r == in_col_r);

  assign line1   = fwd1_r ? fwd_data_r : ram_q;
  assign top1    = line1[LINE_W-1:PIX_W];
  assign mid1    = line1[PIX_W-1:0];
  assign line_wr = {mid1, px1_r};

  cv3f_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (v1_r),
    .wr_addr (col1_r),
    .wr_data (line_wr),
    .rd_en   (take),
    .rd_addr (in_col_r),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ctl1_r     <= ctl_a;
      px1_r      <= px_a;
      col1_r     <= in_col_r;
      fwd1_r     <= fwd_nxt;
      fwd_data_r <= line_wr;
    end
  end

  // 3x3 window: row 0 oldest line, column 2 newest pixel
  logic [PIX_W-1:0] win_r [3][3];

  always_ff @(posedge clk) begin
    if (v1_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= top1;
      win_r[1][2] <= mid1;
      win_r[2][2] <= px1_r;
    end
  end

  // ---------------- stage 2: kernel sums ----------------
  logic v2_r;
  ctl_t ctl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r && ctl1_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      ctl2_r <= ctl1_r;
    end
  end

  taps_t                   taps2 [NUM_CH];
  logic signed [SUM_W-1:0] sum2  [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          taps2[c][r*3 + k] = win_r[r][k][c*CH_W +: CH_W];
        end
      end
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_sum
    cv3f_chan_sum u_sum (
      .taps (taps2[c]),
      .mode (mode_r),
      .sum  (sum2[c])
    );
  end

  // ---------------- stage 3: divide or clamp ----------------
  logic                    v3_r;
  logic                    interior3_r;
  logic                    last3_r;
  logic                    blur3_r;
  logic [PIX_W-1:0]        center3_r;
  logic signed [SUM_W-1:0] sum3_r [NUM_CH];
  logic [CH_W-1:0]         chan3  [NUM_CH];
  res_t                    res3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      interior3_r <= ctl2_r.interior;
      last3_r     <= ctl2_r.last;
      blur3_r     <= (mode_r == MODE_BLUR);
      center3_r   <= win_r[1][1];
      for (int c = 0; c < NUM_CH; c++) begin
        sum3_r[c] <= sum2[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (!interior3_r) begin
        chan3[c] = center3_r[c*CH_W +: CH_W];
      end else if (blur3_r) begin
        chan3[c] = div9(sum3_r[c][SUM_W-2:0]);
      end else begin
        chan3[c] = clamp8(sum3_r[c]);
      end
    end
    res3.red   = chan3[0];
    res3.green = chan3[1];
    res3.blue  = chan3[2];
    res3.last  = last3_r;
  end

  // ---------------- result queue ----------------
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fifo_cnt_r;
  logic             push, pop;
  logic [OCC_W-1:0] occ;

  assign push = v3_r;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fifo_cnt_r <= fifo_cnt_r + CNT_W'(1);
        2'b01:   fifo_cnt_r <= fifo_cnt_r - CNT_W'(1);
        default: fifo_cnt_r <= fifo_cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res3;
    end
  end

  // Results owed: queued plus every emitting beat still in the pipeline
  assign occ = OCC_W'(fifo_cnt_r) + OCC_W'(v1_r && ctl1_r.emit) +
               OCC_W'(v2_r) + OCC_W'(v3_r);
  assign in_stall = (occ >= OCC_W'(FIFO_DEPTH));

  assign out_valid      = (fifo_cnt_r != '0);
  assign out_red        = fifo_r[rd_ptr_r].red;
  assign out_green      = fifo_r[rd_ptr_r].green;
  assign out_blue       = fifo_r[rd_ptr_r].blue;
  assign out_last_pixel = fifo_r[rd_ptr_r].last;

  // ---------------- assertions ----------------
  a_owed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("more results owed than the queue can hold");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (fifo_cnt_r == CNT_W'(FIFO_DEPTH))))
    else $error("result pushed into a full queue");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && ctl_a.emit && ctl_a.last) |=>
      ((in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0)))
    else $error("counters not cleared after the last pixel of a frame");

  a_fwd_one_col: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && fwd1_r && ctl1_r.emit && !ctl1_r.last) |-> (col1_r == '0))
    else $error("line RAM bypass used on a column other than zero");

endmodule
